>>> src/btlv_pkg.sv
// Package for the BER TLV header parser: phase and status codes,
// parser state, input item and result types. No dependencies.
package btlv_pkg;

  localparam int unsigned LEN_OCTETS_MAX = 8;
  localparam logic [30:0] TAG_LIMIT      = 31'h7FFF_FFFF >> 7;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TAG  = 3'd1,
    PH_LEN1 = 3'd2,
    PH_LENN = 3'd3
  } btlv_phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_ERROR    = 2'd2
  } btlv_status_t;

  typedef struct packed {
    btlv_phase_t phase;
    logic [30:0] bytes_left;
    logic [30:0] avail_total;
    logic [30:0] tag_accum;
    logic        constructed_flag;
    logic [1:0]  class_bits;
    logic [6:0]  length_octets_left;
    logic [6:0]  significant_octets;
    logic [63:0] length_accum;
    logic [30:0] header_count;
  } btlv_state_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_req;
    logic [30:0] avail_bytes;
  } btlv_item_t;

  typedef struct packed {
    btlv_status_t status;
    logic         constructed;
    logic         indefinite;
    logic [1:0]   tag_class;
    logic [30:0]  tag_number;
    logic [62:0]  content_length;
    logic [30:0]  header_bytes;
  } btlv_result_t;

endpackage

>>> src/btlv_step.sv
// Combinational decode of one header byte: next parser state and result.
// Depends on btlv_pkg.
module btlv_step (
  input  btlv_pkg::btlv_state_t  state_i,
  input  btlv_pkg::btlv_item_t   item_i,
  output btlv_pkg::btlv_state_t  state_o,
  output logic                   res_valid_o,
  output btlv_pkg::btlv_result_t res_o
);

  always_comb begin
    btlv_pkg::btlv_state_t nx;
    logic        fail_v;
    logic        fin_v;
    logic        indef_v;
    logic [63:0] len_v;
    logic [30:0] bl_dec;
    logic [30:0] hc_inc;
    logic [30:0] tag_n;
    logic [63:0] acc_n;
    logic [6:0]  lol_n;
    logic [30:0] rem_v;
    logic [7:0]  b;

    nx      = state_i;
    fail_v  = 1'b0;
    fin_v   = 1'b0;
    indef_v = 1'b0;
    len_v   = '0;
    b       = item_i.data_byte;
    bl_dec  = (state_i.bytes_left != '0) ? state_i.bytes_left - 31'd1 : state_i.bytes_left;
    hc_inc  = state_i.header_count + 31'd1;
    tag_n   = {state_i.tag_accum[23:0], b[6:0]};
    acc_n   = state_i.length_accum;
    lol_n   = state_i.length_octets_left;

    if (item_i.start_req) begin
      nx             = '0;
      nx.phase       = btlv_pkg::PH_IDLE;
      nx.avail_total = item_i.avail_bytes;
      nx.bytes_left  = item_i.avail_bytes;
      if (item_i.avail_bytes == '0) begin
        fail_v = 1'b1;
      end else begin
        nx.class_bits       = b[7:6];
        nx.constructed_flag = b[5];
        nx.bytes_left       = item_i.avail_bytes - 31'd1;
        nx.header_count     = 31'd1;
        if (item_i.avail_bytes == 31'd1) begin
          fail_v = 1'b1;
        end else if (b[4:0] == 5'h1F) begin
          nx.tag_accum = '0;
          nx.phase     = btlv_pkg::PH_TAG;
        end else begin
          nx.tag_accum = {26'd0, b[4:0]};
          nx.phase     = btlv_pkg::PH_LEN1;
        end
      end
    end else begin
      case (state_i.phase)
        btlv_pkg::PH_TAG: begin
          nx.tag_accum    = tag_n;
          nx.bytes_left   = bl_dec;
          nx.header_count = hc_inc;
          if (bl_dec == '0) begin
            fail_v = 1'b1;
          end else if (b[7]) begin
            if (tag_n > btlv_pkg::TAG_LIMIT) fail_v = 1'b1;
          end else begin
            nx.phase = btlv_pkg::PH_LEN1;
          end
        end
        btlv_pkg::PH_LEN1: begin
          nx.bytes_left   = bl_dec;
          nx.header_count = hc_inc;
          if (b == 8'h80) begin
            fin_v   = 1'b1;
            indef_v = 1'b1;
          end else if (!b[7]) begin
            nx.length_accum = {57'd0, b[6:0]};
            len_v           = {57'd0, b[6:0]};
            fin_v           = 1'b1;
          end else if (bl_dec < {24'd0, b[6:0]}) begin
            fail_v = 1'b1;
          end else begin
            nx.length_octets_left = b[6:0];
            nx.significant_octets = '0;
            nx.length_accum       = '0;
            nx.phase              = btlv_pkg::PH_LENN;
          end
        end
        btlv_pkg::PH_LENN: begin
          nx.bytes_left   = bl_dec;
          nx.header_count = hc_inc;
          if (state_i.significant_octets != '0 || b != 8'h00) begin
            if (state_i.significant_octets == '0 &&
                state_i.length_octets_left > 7'(btlv_pkg::LEN_OCTETS_MAX)) begin
              fail_v = 1'b1;
            end else begin
              nx.significant_octets = state_i.significant_octets + 7'd1;
              acc_n                 = {state_i.length_accum[55:0], b};
              nx.length_accum       = acc_n;
            end
          end
          if (!fail_v) begin
            if (lol_n != '0) lol_n = lol_n - 7'd1;
            nx.length_octets_left = lol_n;
            if (lol_n == '0) begin
              if (acc_n[63]) begin
                fail_v = 1'b1;
              end else begin
                fin_v = 1'b1;
                len_v = acc_n;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (fin_v && indef_v && !nx.constructed_flag) begin
      fin_v  = 1'b0;
      fail_v = 1'b1;
    end

    rem_v = (nx.header_count <= nx.avail_total) ? nx.avail_total - nx.header_count : '0;

    res_o = '0;
    res_o.status = btlv_pkg::ST_ERROR;
    if (fin_v) begin
      res_o.status         = (len_v > {33'd0, rem_v}) ? btlv_pkg::ST_TOO_LONG
                                                      : btlv_pkg::ST_OK;
      res_o.constructed    = nx.constructed_flag;
      res_o.indefinite     = indef_v;
      res_o.tag_class      = nx.class_bits;
      res_o.tag_number     = nx.tag_accum;
      res_o.content_length = len_v[62:0];
      res_o.header_bytes   = nx.header_count;
    end
    if (fail_v || fin_v) nx.phase = btlv_pkg::PH_IDLE;

    res_valid_o = fail_v | fin_v;
    state_o     = nx;
  end

endmodule

>>> src/ber_tlv_header_parser_core.sv
// Top level of the BER TLV header parser: input register, parser state,
// result register and stream handshakes. Depends on btlv_pkg, btlv_step.
//
//  channel | dir | payload                                   | handshake
//  in_     | in  | tdata: data_byte, avail_bytes; tuser: start | tvalid/tready
//  out_    | out | tdata: status .. header_bytes              | tvalid/tready
//
// One byte per cycle sustained while no result stalls; a byte is decoded
// from the input register and its result (if any) is shown registered.
// The throughput is set by the single decode step between the input and
// result registers. Reset clears the handshake registers and the parser
// state to idle. A stalled result holds back decoding; input is still taken
// into the input register while it is empty.
module ber_tlv_header_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // data_byte[7:0], avail_bytes[38:8], zero pad
  input  logic         in_tuser,   // start_req
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata   // status, constructed, indefinite, tag_class,
                                   // tag_number, content_length, header_bytes, pad
);

  logic                   in_valid_r;
  btlv_pkg::btlv_item_t   item_r;
  btlv_pkg::btlv_state_t  state_r;
  btlv_pkg::btlv_state_t  state_nxt;
  logic                   out_valid_r;
  btlv_pkg::btlv_result_t res_r;
  btlv_pkg::btlv_result_t res_nxt;
  logic                   res_valid;
  logic                   proc;

  assign proc      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc;

  btlv_step u_step (
    .state_i     (state_r),
    .item_i      (item_r),
    .state_o     (state_nxt),
    .res_valid_o (res_valid),
    .res_o       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (proc) state_r <= state_nxt;
      if (proc && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data_byte   <= in_tdata[7:0];
      item_r.avail_bytes <= in_tdata[38:8];
      item_r.start_req   <= in_tuser;
    end
    if (proc && res_valid) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.header_bytes, res_r.content_length, res_r.tag_number,
                       res_r.tag_class, res_r.indefinite, res_r.constructed, res_r.status};

`ifndef NO_ASSERTIONS
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && res_valid) |=> (state_r.phase == btlv_pkg::PH_IDLE && out_tvalid))
    else $error("parser not idle after a result");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && !(proc && res_valid)) |=> !out_tvalid)
    else $error("result repeated after transaction");
`endif

endmodule
